[rtl/ckmsb_pkg.sv]
// Shared types and constants for the colour-keyed mirror stretch blitter.
`default_nettype none

package ckmsb_pkg;

    localparam int PIXEL_W    = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int MODE_W     = 4;
    localparam int HALF_W     = 16;
    localparam int DDA_W      = 16;
    localparam int OUT_ADDR_W = 24;
    localparam int KIND_W     = 2;
    localparam int ACT_W      = 1;
    localparam int OUT_DATA_W = OUT_ADDR_W + PIXEL_W;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DST_ORIGIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DST_SIZE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_ORIGIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_SIZE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTHS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd7;

    // input word selector
    localparam logic [ACT_W-1:0] ACT_START = 1'b0;
    localparam logic [ACT_W-1:0] ACT_PIXEL = 1'b1;

    // result word kinds
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

    // pixel depth codes in mode[1:0]
    localparam logic [1:0] DEPTH_8   = 2'd0;
    localparam logic [1:0] DEPTH_16  = 2'd1;
    localparam logic [1:0] DEPTH_32  = 2'd2;
    localparam logic [1:0] DEPTH_BAD = 2'd3;

    typedef struct packed {
        logic              load_in;
        logic              clear;
        logic              div_go;
        logic              div_row;
        logic              set_busy;
        logic              clr_busy;
        logic              addr_go;
        logic              addr_dst;
        logic              advance;
        logic              emit;
        logic [KIND_W-1:0] emit_kind;
        logic              emit_last;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic cfg_bad;
        logic depth_bad;
        logic div_done;
        logic transparent;
        logic walk_end;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[rtl/color_key_mirror_stretch_blit.sv]
// Top level of the colour-keyed, mirrored, nearest-neighbour stretch blitter.
`default_nettype none

// A start word (tuser 0) uses none of its data but begins a stretch of the
// source rectangle onto the destination rectangle using the live registers;
// the column and row steps are set up in turn by one shared restoring divider
// before the first source read is presented. Each returned pixel word
// (tuser 1) then steps through the key test, the destination address
// product, the write word, the DDA advance, the source address product and
// the read word when it is written, and skips the destination address
// product and the write word when it falls in the colour-key range; the
// sequence is set by the single registered address multiplier, used once
// for the destination and once for the source. A new input word is taken
// as soon as the last result word of the previous one sits in the output
// register. A bad depth code or a zero size gives a done word at once.
// Addresses are pixel indices, wrapped to ADDR_BITS and shown in 24 bits.
module color_key_mirror_stretch_blit #(
    parameter int ADDR_BITS  = 24,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input words
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [ckmsb_pkg::PIXEL_W-1:0]       s_tdata,   // pixel[31:0]
    input  wire logic [ckmsb_pkg::ACT_W-1:0]         s_tuser,   // action[0]
    // result words
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [ckmsb_pkg::OUT_DATA_W-1:0]         m_tdata,   // address[23:0], write_data[55:24]
    output logic [ckmsb_pkg::KIND_W-1:0]             m_tuser,   // kind[1:0]
    output logic                                     m_tlast,
    // register writes
    input  wire logic                                cfg_we,
    input  wire logic [ckmsb_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [ckmsb_pkg::CFG_W-1:0]         cfg_wdata
);

    import ckmsb_pkg::*;

    cmd_t    cmd;
    status_t status;

    ckmsb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    ckmsb_datapath #(
        .ADDR_BITS  (ADDR_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_pixel  (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

[rtl/ckmsb_div.sv]
// Restoring divider, one quotient bit per cycle, for the DDA step setup.
`default_nettype none

module ckmsb_div #(
    parameter int W = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         go,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);

    localparam int CNT_W = $clog2(W + 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(W);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     q_reg, q_next;
    logic [W-1:0]     r_reg, r_next;
    logic [W-1:0]     d_reg, d_next;
    logic [W:0]       trial;
    logic [W:0]       diff;

    assign trial = {r_reg, q_reg[W-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (go) begin
            run_next = 1'b1;
            cnt_next = CNT_FULL;
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
        end else if (run_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = diff[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end else begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_ONE;
            if (cnt_reg == CNT_ONE) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

`default_nettype wire

[rtl/ckmsb_datapath.sv]
// Blitter datapath: registers, DDA walk, address unit, key test, result register.
`default_nettype none

module ckmsb_datapath #(
    parameter int ADDR_BITS  = 24,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [ckmsb_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [ckmsb_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire logic [ckmsb_pkg::PIXEL_W-1:0]       in_pixel,
    input  wire ckmsb_pkg::cmd_t                     cmd,
    output ckmsb_pkg::status_t                       status,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [ckmsb_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic [ckmsb_pkg::KIND_W-1:0]             m_tuser,
    output logic                                     m_tlast
);

    import ckmsb_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int CB = COORD_BITS;
    localparam logic [AW-1:0] ADDR_ONE = AW'(1);
    localparam logic [DDA_W-1:0] DDA_ONE = DDA_W'(1);

    function automatic logic [PIXEL_W-1:0] depth_mask(input logic [1:0] code);
        logic [PIXEL_W-1:0] m;
        unique case (code)
            DEPTH_8:  m = PIXEL_W'(32'h0000_00FF);
            DEPTH_16: m = PIXEL_W'(32'h0000_FFFF);
            default:  m = '1;
        endcase
        return m;
    endfunction

    // configuration registers
    logic [CFG_W-1:0]  dst_origin_reg, dst_size_reg, src_origin_reg, src_size_reg;
    logic [CFG_W-1:0]  surface_widths_reg, key_low_reg, key_high_reg;
    logic [MODE_W-1:0] mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dst_origin_reg     <= '0;
            dst_size_reg       <= '0;
            src_origin_reg     <= '0;
            src_size_reg       <= '0;
            surface_widths_reg <= '0;
            key_low_reg        <= '0;
            key_high_reg       <= '0;
            mode_reg           <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DST_ORIGIN:     dst_origin_reg     <= cfg_wdata;
                REG_DST_SIZE:       dst_size_reg       <= cfg_wdata;
                REG_SRC_ORIGIN:     src_origin_reg     <= cfg_wdata;
                REG_SRC_SIZE:       src_size_reg       <= cfg_wdata;
                REG_SURFACE_WIDTHS: surface_widths_reg <= cfg_wdata;
                REG_KEY_LOW:        key_low_reg        <= cfg_wdata;
                REG_KEY_HIGH:       key_high_reg       <= cfg_wdata;
                REG_MODE:           mode_reg           <= cfg_wdata[MODE_W-1:0];
            endcase
        end
    end

    logic [CB-1:0] dox, doy, dw, dh, sox, soy, sw, sh, dpitch, spitch;
    logic [1:0]    depth;
    logic          mir_v, mir_h;

    assign dox    = dst_origin_reg[CB-1:0];
    assign doy    = dst_origin_reg[HALF_W+CB-1:HALF_W];
    assign dw     = dst_size_reg[CB-1:0];
    assign dh     = dst_size_reg[HALF_W+CB-1:HALF_W];
    assign sox    = src_origin_reg[CB-1:0];
    assign soy    = src_origin_reg[HALF_W+CB-1:HALF_W];
    assign sw     = src_size_reg[CB-1:0];
    assign sh     = src_size_reg[HALF_W+CB-1:HALF_W];
    assign dpitch = surface_widths_reg[CB-1:0];
    assign spitch = surface_widths_reg[HALF_W+CB-1:HALF_W];
    assign depth  = mode_reg[1:0];
    assign mir_v  = mode_reg[2];
    assign mir_h  = mode_reg[3];

    // returned pixel and key test
    logic [PIXEL_W-1:0] pixel_reg;
    logic [PIXEL_W-1:0] pmask, pix_c, key_lo_c, key_hi_c;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            pixel_reg <= in_pixel;
        end
    end

    assign pmask    = depth_mask(depth);
    assign pix_c    = pixel_reg & pmask;
    assign key_lo_c = key_low_reg & pmask;
    assign key_hi_c = key_high_reg & pmask;

    // DDA step setup divider, shared by column and row
    logic          div_done;
    logic [CB-1:0] div_q, div_r;
    logic          div_row_reg;

    ckmsb_div #(
        .W (CB)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .go        (cmd.div_go),
        .dividend  (cmd.div_row ? sh : sw),
        .divisor   (cmd.div_row ? dh : dw),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // walk state
    logic             busy_reg, end_reg;
    logic [DDA_W-1:0] dst_col_reg, dst_row_reg, scol_reg, crem_reg, srow_reg, rrem_reg;
    logic [DDA_W-1:0] cwhole_reg, cfrac_reg, rwhole_reg, rfrac_reg;

    logic [DDA_W-1:0] col_n, row_n, scol_sum, srow_sum, scol_adj, srow_adj;
    logic [DDA_W:0]   crem_sum, rrem_sum, crem_adj, rrem_adj;
    logic [DDA_W:0]   dw_x, dh_x;
    logic             col_wrap, row_end;

    assign dw_x     = (DDA_W+1)'(dw);
    assign dh_x     = (DDA_W+1)'(dh);
    assign col_n    = dst_col_reg + DDA_ONE;
    assign row_n    = dst_row_reg + DDA_ONE;
    assign crem_sum = {1'b0, crem_reg} + {1'b0, cfrac_reg};
    assign rrem_sum = {1'b0, rrem_reg} + {1'b0, rfrac_reg};
    assign scol_sum = scol_reg + cwhole_reg;
    assign srow_sum = srow_reg + rwhole_reg;

    always_comb begin
        if (crem_sum >= dw_x) begin
            crem_adj = crem_sum - dw_x;
            scol_adj = scol_sum + DDA_ONE;
        end else begin
            crem_adj = crem_sum;
            scol_adj = scol_sum;
        end
        if (rrem_sum >= dh_x) begin
            rrem_adj = rrem_sum - dh_x;
            srow_adj = srow_sum + DDA_ONE;
        end else begin
            rrem_adj = rrem_sum;
            srow_adj = srow_sum;
        end
    end

    assign col_wrap = col_n >= DDA_W'(dw);
    assign row_end  = row_n >= DDA_W'(dh);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            end_reg     <= 1'b0;
            div_row_reg <= 1'b0;
            dst_col_reg <= '0;
            dst_row_reg <= '0;
            scol_reg    <= '0;
            crem_reg    <= '0;
            srow_reg    <= '0;
            rrem_reg    <= '0;
            cwhole_reg  <= '0;
            cfrac_reg   <= '0;
            rwhole_reg  <= '0;
            rfrac_reg   <= '0;
        end else begin
            if (cmd.div_go) begin
                div_row_reg <= cmd.div_row;
            end
            if (div_done) begin
                if (div_row_reg) begin
                    rwhole_reg <= DDA_W'(div_q);
                    rfrac_reg  <= DDA_W'(div_r);
                end else begin
                    cwhole_reg <= DDA_W'(div_q);
                    cfrac_reg  <= DDA_W'(div_r);
                end
            end
            if (cmd.set_busy) begin
                busy_reg <= 1'b1;
            end else if (cmd.clr_busy) begin
                busy_reg <= 1'b0;
            end
            if (cmd.clear) begin
                busy_reg    <= 1'b0;
                end_reg     <= 1'b0;
                dst_col_reg <= '0;
                dst_row_reg <= '0;
                scol_reg    <= '0;
                crem_reg    <= '0;
                srow_reg    <= '0;
                rrem_reg    <= '0;
            end else if (cmd.advance) begin
                if (col_wrap) begin
                    dst_col_reg <= '0;
                    scol_reg    <= '0;
                    crem_reg    <= '0;
                    dst_row_reg <= row_n;
                    srow_reg    <= srow_adj;
                    rrem_reg    <= rrem_adj[DDA_W-1:0];
                    end_reg     <= row_end;
                end else begin
                    dst_col_reg <= col_n;
                    scol_reg    <= scol_adj;
                    crem_reg    <= crem_adj[DDA_W-1:0];
                    end_reg     <= 1'b0;
                end
            end
        end
    end

    // address unit: row product registered, column offset added on emit
    logic [AW-1:0] col_src, row_src;
    logic [AW-1:0] base_sel, rowv_sel, pitch_sel;
    logic [AW-1:0] mul_reg, base_reg;

    assign col_src = mir_h ? (AW'(sw) - ADDR_ONE - AW'(scol_reg)) : AW'(scol_reg);
    assign row_src = mir_v ? (AW'(sh) - ADDR_ONE - AW'(srow_reg)) : AW'(srow_reg);

    always_comb begin
        if (cmd.addr_dst) begin
            base_sel  = AW'(dox) + AW'(dst_col_reg);
            rowv_sel  = AW'(doy) + AW'(dst_row_reg);
            pitch_sel = AW'(dpitch);
        end else begin
            base_sel  = AW'(sox) + col_src;
            rowv_sel  = AW'(soy) + row_src;
            pitch_sel = AW'(spitch);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.addr_go) begin
            mul_reg  <= pitch_sel * rowv_sel;
            base_reg <= base_sel;
        end
    end

    // result register
    logic                  m_valid_reg;
    logic [KIND_W-1:0]     m_kind_reg;
    logic [OUT_ADDR_W-1:0] m_addr_reg;
    logic [PIXEL_W-1:0]    m_data_reg;
    logic                  m_last_reg;
    logic                  out_free;
    logic [AW-1:0]         addr_sum;

    assign out_free = !m_valid_reg || m_tready;
    assign addr_sum = mul_reg + base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            m_kind_reg <= cmd.emit_kind;
            m_last_reg <= cmd.emit_last;
            m_addr_reg <= (cmd.emit_kind == KIND_DONE) ? '0 : OUT_ADDR_W'(addr_sum);
            m_data_reg <= (cmd.emit_kind == KIND_WRITE) ? pix_c : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg, m_addr_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    assign status.busy        = busy_reg;
    assign status.cfg_bad     = (depth == DEPTH_BAD) || (dw == '0) || (dh == '0) ||
                                (sw == '0) || (sh == '0);
    assign status.depth_bad   = depth == DEPTH_BAD;
    assign status.div_done    = div_done;
    assign status.transparent = (pix_c >= key_lo_c) && (pix_c <= key_hi_c);
    assign status.walk_end    = end_reg;
    assign status.out_free    = out_free;

endmodule

`default_nettype wire

[rtl/ckmsb_ctrl.sv]
// Blitter sequencer: start setup, per-pixel write/advance/read steps.
`default_nettype none

module ckmsb_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ckmsb_pkg::ACT_W-1:0]   s_tuser,
    input  wire ckmsb_pkg::status_t            status,
    output ckmsb_pkg::cmd_t                    cmd
);

    import ckmsb_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE       = 10'b00_0000_0001,
        S_START      = 10'b00_0000_0010,
        S_DIV_COL    = 10'b00_0000_0100,
        S_DIV_ROW    = 10'b00_0000_1000,
        S_SRC_MUL    = 10'b00_0001_0000,
        S_EMIT_READ  = 10'b00_0010_0000,
        S_PIX        = 10'b00_0100_0000,
        S_EMIT_WRITE = 10'b00_1000_0000,
        S_ADV        = 10'b01_0000_0000,
        S_CHECK      = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   done_pend_reg, done_pend_next;

    // a done word waits in S_CHECK-less form: done_pend marks the emit-done step
    always_comb begin
        state_next     = state_reg;
        done_pend_next = done_pend_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        if (done_pend_reg) begin
            if (status.out_free) begin
                cmd.emit       = 1'b1;
                cmd.emit_kind  = KIND_DONE;
                cmd.emit_last  = 1'b1;
                done_pend_next = 1'b0;
                state_next     = S_IDLE;
            end
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    s_tready = 1'b1;
                    if (s_tvalid) begin
                        cmd.load_in = 1'b1;
                        if (s_tuser == ACT_START) begin
                            state_next = S_START;
                        end else if (status.busy) begin
                            state_next = S_PIX;
                        end
                    end
                end
                S_START: begin
                    cmd.clear = 1'b1;
                    if (status.cfg_bad) begin
                        done_pend_next = 1'b1;
                    end else begin
                        cmd.div_go = 1'b1;
                        state_next = S_DIV_COL;
                    end
                end
                S_DIV_COL: begin
                    if (status.div_done) begin
                        cmd.div_go  = 1'b1;
                        cmd.div_row = 1'b1;
                        state_next  = S_DIV_ROW;
                    end
                end
                S_DIV_ROW: begin
                    if (status.div_done) begin
                        cmd.set_busy = 1'b1;
                        state_next   = S_SRC_MUL;
                    end
                end
                S_SRC_MUL: begin
                    cmd.addr_go = 1'b1;
                    state_next  = S_EMIT_READ;
                end
                S_EMIT_READ: begin
                    if (status.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_READ;
                        cmd.emit_last = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                S_PIX: begin
                    if (status.depth_bad) begin
                        cmd.clr_busy   = 1'b1;
                        done_pend_next = 1'b1;
                    end else if (status.transparent) begin
                        state_next = S_ADV;
                    end else begin
                        cmd.addr_go  = 1'b1;
                        cmd.addr_dst = 1'b1;
                        state_next   = S_EMIT_WRITE;
                    end
                end
                S_EMIT_WRITE: begin
                    if (status.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_WRITE;
                        state_next    = S_ADV;
                    end
                end
                S_ADV: begin
                    cmd.advance = 1'b1;
                    state_next  = S_CHECK;
                end
                S_CHECK: begin
                    if (status.walk_end) begin
                        cmd.clr_busy   = 1'b1;
                        done_pend_next = 1'b1;
                    end else begin
                        cmd.addr_go = 1'b1;
                        state_next  = S_EMIT_READ;
                    end
                end
                default: begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            done_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            done_pend_reg <= done_pend_next;
        end
    end

endmodule

`default_nettype wire

[bench/blit_request_checker.sv]
// Checker for the stretch blitter: tracks registers, predicts request words, compares them.
`timescale 1ns / 100ps

module blit_request_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    input  wire logic                                s_tready,
    input  wire logic [ckmsb_pkg::PIXEL_W-1:0]       s_tdata,
    input  wire logic [ckmsb_pkg::ACT_W-1:0]         s_tuser,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [ckmsb_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  wire logic [ckmsb_pkg::KIND_W-1:0]        m_tuser,
    input  wire logic                                m_tlast,
    input  wire logic                                cfg_we,
    input  wire logic [ckmsb_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [ckmsb_pkg::CFG_W-1:0]         cfg_wdata,
    output int                                       mismatches,
    output int                                       outstanding
);

    import ckmsb_pkg::*;

    typedef struct {
        logic [KIND_W-1:0]     kind;
        logic [OUT_ADDR_W-1:0] address;
        logic [PIXEL_W-1:0]    wdata;
        logic                  tail;
    } blit_word_t;

    blit_word_t due_requests[$];

    // live register copies
    bit [31:0] dst_origin, dst_size, src_origin, src_size, pitches, key_lo, key_hi;
    bit [3:0]  mode_r;

    // walk state
    bit        walking;
    bit [15:0] dcol, drow, scol, crem, srow, rrem;
    bit [15:0] cstep_whole, cstep_frac, rstep_whole, rstep_frac;

    initial mismatches = 0;

    task automatic flag_mismatch(input string what);
        $display("%0t ns: blit word mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic queue_request(input logic [KIND_W-1:0] kind, input bit [23:0] addr,
                                 input bit [31:0] data, input bit tail);
        blit_word_t w;
        w.kind    = kind;
        w.address = addr;
        w.wdata   = data;
        w.tail    = tail;
        due_requests.push_back(w);
    endtask

    function automatic bit [23:0] source_index();
        bit [31:0] c, r, sum;
        c = 32'(scol);
        r = 32'(srow);
        if (mode_r[3]) c = 32'(src_size[15:0]) - 32'd1 - c;
        if (mode_r[2]) r = 32'(src_size[31:16]) - 32'd1 - r;
        sum = 32'(src_origin[15:0]) + c
            + 32'(pitches[31:16]) * (32'(src_origin[31:16]) + r);
        return sum[23:0];
    endfunction

    function automatic bit [23:0] dest_index();
        bit [31:0] sum;
        sum = 32'(dst_origin[15:0]) + 32'(dcol)
            + 32'(pitches[15:0]) * (32'(dst_origin[31:16]) + 32'(drow));
        return sum[23:0];
    endfunction

    task automatic predict_requests(input logic [ACT_W-1:0] act, input bit [31:0] px);
        bit [31:0] dw, dh, sw, sh, msk, c, kl, kh, rem, acc;
        bit [1:0]  depth;
        dw    = 32'(dst_size[15:0]);
        dh    = 32'(dst_size[31:16]);
        sw    = 32'(src_size[15:0]);
        sh    = 32'(src_size[31:16]);
        depth = mode_r[1:0];
        if (act == ACT_START) begin
            walking = 1'b0;
            dcol = '0; drow = '0; scol = '0; crem = '0; srow = '0; rrem = '0;
            if (depth == DEPTH_BAD || dw == 0 || dh == 0 || sw == 0 || sh == 0) begin
                queue_request(KIND_DONE, '0, '0, 1'b1);
            end else begin
                cstep_whole = 16'(sw / dw);
                cstep_frac  = 16'(sw % dw);
                rstep_whole = 16'(sh / dh);
                rstep_frac  = 16'(sh % dh);
                walking     = 1'b1;
                queue_request(KIND_READ, source_index(), '0, 1'b1);
            end
        end else if (walking) begin
            if (depth == DEPTH_BAD) begin
                walking = 1'b0;
                queue_request(KIND_DONE, '0, '0, 1'b1);
            end else begin
                msk = (depth == DEPTH_8) ? 32'hFF : (depth == DEPTH_16) ? 32'hFFFF : '1;
                c   = px & msk;
                kl  = key_lo & msk;
                kh  = key_hi & msk;
                // inside the key range means transparent: no write
                if (c < kl || c > kh) queue_request(KIND_WRITE, dest_index(), c, 1'b0);
                dcol = dcol + 16'd1;
                rem  = 32'(crem) + 32'(cstep_frac);
                acc  = 32'(scol) + 32'(cstep_whole);
                if (rem >= dw) begin
                    rem = rem - dw;
                    acc = acc + 32'd1;
                end
                crem = rem[15:0];
                scol = acc[15:0];
                if (32'(dcol) >= dw) begin
                    dcol = '0; scol = '0; crem = '0;
                    drow = drow + 16'd1;
                    rem  = 32'(rrem) + 32'(rstep_frac);
                    acc  = 32'(srow) + 32'(rstep_whole);
                    if (rem >= dh) begin
                        rem = rem - dh;
                        acc = acc + 32'd1;
                    end
                    rrem = rem[15:0];
                    srow = acc[15:0];
                    if (32'(drow) >= dh) begin
                        walking = 1'b0;
                        queue_request(KIND_DONE, '0, '0, 1'b1);
                        return;
                    end
                end
                queue_request(KIND_READ, source_index(), '0, 1'b1);
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        blit_word_t want;
        if (!aresetn) begin
            dst_origin = '0; dst_size = '0; src_origin = '0; src_size = '0;
            pitches = '0; key_lo = '0; key_hi = '0; mode_r = '0;
            walking = 1'b0;
            dcol = '0; drow = '0; scol = '0; crem = '0; srow = '0; rrem = '0;
            cstep_whole = '0; cstep_frac = '0; rstep_whole = '0; rstep_frac = '0;
            due_requests.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_DST_ORIGIN:     dst_origin = cfg_wdata;
                    REG_DST_SIZE:       dst_size   = cfg_wdata;
                    REG_SRC_ORIGIN:     src_origin = cfg_wdata;
                    REG_SRC_SIZE:       src_size   = cfg_wdata;
                    REG_SURFACE_WIDTHS: pitches    = cfg_wdata;
                    REG_KEY_LOW:        key_lo     = cfg_wdata;
                    REG_KEY_HIGH:       key_hi     = cfg_wdata;
                    REG_MODE:           mode_r     = cfg_wdata[MODE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_requests(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (due_requests.size() == 0) begin
                    flag_mismatch($sformatf("word with nothing due: kind %0d addr %h data %h",
                                            m_tuser, m_tdata[23:0], m_tdata[55:24]));
                end else begin
                    want = due_requests.pop_front();
                    if (m_tuser !== want.kind)
                        flag_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
                    if (m_tdata[23:0] !== want.address)
                        flag_mismatch($sformatf("address %h, want %h",
                                                m_tdata[23:0], want.address));
                    if (m_tdata[55:24] !== want.wdata)
                        flag_mismatch($sformatf("write data %h, want %h",
                                                m_tdata[55:24], want.wdata));
                    if (m_tlast !== want.tail)
                        flag_mismatch($sformatf("tlast %b, want %b", m_tlast, want.tail));
                end
            end
        end
        outstanding <= due_requests.size();
    end

endmodule

[bench/color_key_mirror_stretch_blit_tb.sv]
// Testbench top for the stretch blitter: clock, reset, register setup and blit traffic.
`timescale 1ns / 100ps

module color_key_mirror_stretch_blit_tb;
    import ckmsb_pkg::*;

    localparam int TARGET_WORDS = 1150;
    localparam int SETTLE       = 50;     // covers the divider set-up after a start
    localparam int HOLD_CYCLES  = 300;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [PIXEL_W-1:0]    s_tdata   = '0;
    logic [ACT_W-1:0]      s_tuser   = ACT_START;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    int fail_count;
    int outstanding;
    int words_sent = 0;
    bit calm       = 1'b0;
    bit hold_off   = 1'b0;
    bit held       = 1'b0;

    bit [31:0] shadow [8];

    color_key_mirror_stretch_blit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    blit_request_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: random back-pressure, one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off = 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 18);
            end
        end
    end

    task automatic send_word(input logic [ACT_W-1:0] act, input bit [31:0] px, input bit counted);
        if (!calm && $urandom_range(0, 99) < 18) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        if (counted) words_sent++;
    endtask

    // wait for every due word, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic load_regs(input bit [31:0] dorg, dsz, sorg, ssz, pitch, klo, khi,
                             input bit [3:0] md);
        shadow[REG_DST_ORIGIN]     = dorg;
        shadow[REG_DST_SIZE]       = dsz;
        shadow[REG_SRC_ORIGIN]     = sorg;
        shadow[REG_SRC_SIZE]       = ssz;
        shadow[REG_SURFACE_WIDTHS] = pitch;
        shadow[REG_KEY_LOW]        = klo;
        shadow[REG_KEY_HIGH]       = khi;
        shadow[REG_MODE]           = {28'd0, md};
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= i[CFG_IDX_W-1:0];
            cfg_wdata <= shadow[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic bit blit_starts();
        return shadow[REG_MODE][1:0] != DEPTH_BAD
            && shadow[REG_DST_SIZE][15:0] != 0 && shadow[REG_DST_SIZE][31:16] != 0
            && shadow[REG_SRC_SIZE][15:0] != 0 && shadow[REG_SRC_SIZE][31:16] != 0;
    endfunction

    // mostly values on or next to the key range edges, the rest anything
    function automatic bit [31:0] pick_pixel();
        bit [31:0] msk, base;
        case (shadow[REG_MODE][1:0])
            DEPTH_8:  msk = 32'hFF;
            DEPTH_16: msk = 32'hFFFF;
            default:  msk = '1;
        endcase
        case ($urandom_range(0, 5))
            0:       base = shadow[REG_KEY_LOW];
            1:       base = shadow[REG_KEY_HIGH];
            2:       base = shadow[REG_KEY_LOW] - 32'd1;
            3:       base = shadow[REG_KEY_HIGH] + 32'd1;
            default: base = $urandom;
        endcase
        return ($urandom & ~msk) | (base & msk);
    endfunction

    task automatic stretch(input bit abandon);
        int n;
        n = shadow[REG_DST_SIZE][15:0] * shadow[REG_DST_SIZE][31:16];
        send_word(ACT_START, $urandom, 1'b1);
        if (blit_starts()) begin
            if (abandon) begin
                repeat ($urandom_range(0, n - 1)) send_word(ACT_PIXEL, pick_pixel(), 1'b1);
                send_word(ACT_START, $urandom, 1'b1);
            end
            repeat (n) send_word(ACT_PIXEL, pick_pixel(), 1'b1);
        end
    endtask

    task automatic random_config();
        bit [15:0] dw, dh, sw, sh;
        bit [31:0] dorg, sorg, pitch, klo, khi;
        bit [1:0]  depth;
        int        pick;
        pick = $urandom_range(0, 19);
        dw = 16'($urandom_range(1, 6));
        dh = 16'($urandom_range(1, 5));
        if (pick == 0) begin
            if ($urandom_range(0, 1)) dw = 16'd0; else dh = 16'd0;
        end else if (pick == 1) begin
            dw = 16'($urandom_range(20, 64));
            dh = 16'd1;
        end
        case ($urandom_range(0, 3))
            0:       sw = 16'($urandom_range(1, 8));
            1:       sw = 16'($urandom_range(1, 16));
            2:       sw = 16'($urandom_range(1, 16'hFFFF));
            default: sw = 16'hFFFF;
        endcase
        case ($urandom_range(0, 3))
            0:       sh = 16'($urandom_range(1, 8));
            1:       sh = 16'($urandom_range(1, 16));
            2:       sh = 16'($urandom_range(1, 16'hFFFF));
            default: sh = 16'hFFFF;
        endcase
        if (pick == 2) sw = 16'd0;
        depth = ($urandom_range(0, 19) == 0) ? DEPTH_BAD : 2'($urandom_range(0, 2));
        dorg  = $urandom;
        sorg  = $urandom;
        pitch = $urandom;
        if ($urandom_range(0, 1)) dorg  &= 32'h00FF_00FF;
        if ($urandom_range(0, 1)) sorg  &= 32'h00FF_00FF;
        if ($urandom_range(0, 1)) pitch &= 32'h01FF_01FF;
        klo = $urandom;
        case ($urandom_range(0, 3))
            0:       khi = klo + $urandom_range(0, 64);
            1:       khi = $urandom;     // often reversed: nothing keyed out
            2:       khi = klo;
            default: begin
                klo = '0;
                khi = '1;
            end
        endcase
        load_regs(dorg, {dh, dw}, sorg, {sh, sw}, pitch, klo, khi,
                  {2'($urandom_range(0, 3)), depth});
    endtask

    initial begin
        for (int i = 0; i < 8; i++) shadow[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // registers at reset: zero sizes finish at once; a pixel word while idle is dropped
        send_word(ACT_START, 32'h0, 1'b1);
        send_word(ACT_PIXEL, 32'hFFFF_FFFF, 1'b0);
        drain();

        // everything at its top value but a zero destination width, key high and mode
        load_regs('1, 32'hFFFF_0000, '1, '1, '1, '1, '0, {1'b0, 1'b0, DEPTH_8});
        send_word(ACT_START, 32'h0, 1'b1);
        drain();

        // one pixel, full-size source mirrored both ways, wrapping addresses, reversed key
        load_regs('1, 32'h0001_0001, '1, '1, '1, '1, '0, {1'b1, 1'b1, DEPTH_8});
        send_word(ACT_START, 32'h0, 1'b1);
        send_word(ACT_PIXEL, 32'hFFFF_FFFF, 1'b1);
        drain();

        // 16 bit, columns stretched up, rows down, vertical mirror, keyed pixels
        load_regs(32'h0005_0003, 32'h0002_0003, 32'h0001_0002, 32'h0003_0002,
                  32'h00C8_0064, 32'h0000_1000, 32'h0000_10FF, {1'b0, 1'b1, DEPTH_16});
        send_word(ACT_START, 32'h0, 1'b1);
        send_word(ACT_PIXEL, 32'h0000_0000, 1'b1);
        send_word(ACT_PIXEL, 32'h0000_FFFF, 1'b1);
        send_word(ACT_PIXEL, 32'h0000_1000, 1'b1);
        send_word(ACT_PIXEL, 32'hABCD_10FF, 1'b1);
        send_word(ACT_PIXEL, 32'h5555_1100, 1'b1);
        send_word(ACT_PIXEL, 32'h0000_0FFF, 1'b1);
        drain();

        // 32 bit, horizontal mirror, restart in the middle of a blit
        load_regs(32'h0, 32'h0002_0002, 32'h0003_0004, 32'h0004_0005, 32'h0010_0020,
                  32'h0, 32'h0, {1'b1, 1'b0, DEPTH_32});
        send_word(ACT_START, 32'h0, 1'b1);
        send_word(ACT_PIXEL, 32'h0000_0001, 1'b1);
        send_word(ACT_START, 32'h0, 1'b1);
        send_word(ACT_PIXEL, 32'h0000_0000, 1'b1);
        send_word(ACT_PIXEL, 32'hFFFF_FFFF, 1'b1);
        send_word(ACT_PIXEL, 32'h8000_0000, 1'b1);
        send_word(ACT_PIXEL, 32'h7FFF_FFFF, 1'b1);
        drain();

        // bad depth code at start
        load_regs(32'h0, 32'h0002_0002, 32'h0003_0004, 32'h0004_0005, 32'h0010_0020,
                  32'h0, 32'h0, {1'b1, 1'b1, DEPTH_BAD});
        send_word(ACT_START, 32'h0, 1'b1);
        drain();

        while (words_sent < TARGET_WORDS) begin
            calm = (words_sent >= 500 && words_sent < 700);
            random_config();
            if (!held && words_sent >= 300 && blit_starts()) begin
                hold_off = 1'b1;
                held     = 1'b1;
            end
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 9) == 0) send_word(ACT_PIXEL, $urandom, 1'b0);
                stretch($urandom_range(0, 4) == 0);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/ckmsb_pkg.sv
rtl/ckmsb_div.sv
rtl/ckmsb_datapath.sv
rtl/ckmsb_ctrl.sv
rtl/color_key_mirror_stretch_blit.sv
bench/blit_request_checker.sv
bench/color_key_mirror_stretch_blit_tb.sv
